// ===== sv/slu_pkg.sv =====
// shared constants and stage data type for the logistic sigmoid unit
package slu_pkg;

    // default geometry of the top level
    localparam int DEF_IN_WIDTH     = 16;
    localparam int DEF_IN_FRAC_BITS = 12;
    localparam int DEF_OUT_WIDTH    = 16;

    // fixed point formats of the exponential core
    localparam int R_W  = 62;                   // reduced argument, Q62
    localparam int S_W  = 63;                   // series value, Q62 up to 1.0
    localparam int K_W  = 7;                    // ln2 multiple, up to 92
    localparam int AV_W = 62;                   // |x| in Q6.56
    localparam int D_W  = 64;                   // quotient divider width

    localparam logic [S_W-1:0] Q62_ONE = 63'h4000_0000_0000_0000;
    localparam logic [55:0]    LN2_Q56 = 56'hB1_7217_F7D1_CF7A;

    // series order and the constant divider layout
    localparam int TAYLOR_ORDER = 20;
    localparam int REM_W        = $clog2(TAYLOR_ORDER);
    localparam int CHUNK_W      = 16;
    localparam int N_CHUNK      = 4;

    // data that travels with each element through the exponential core
    typedef struct packed {
        logic [R_W-1:0] r;
        logic [S_W-1:0] s;
        logic [K_W-1:0] k;
        logic           neg;
        logic           big;
        logic           last;
    } t_hdata;

endpackage

// ===== sv/logistic_sigmoid_unit.sv =====
// top level of the logistic sigmoid unit: core pipeline, output register and skid
//
//  channel | valid   | stall   | payload
//  --------+---------+---------+-----------------------
//  input   | i_valid | o_stall | i_x_value, i_last_in
//  output  | o_valid | i_stall | o_y_value, o_last_out
//
// one element per cycle is taken and delivered while nothing stalls.
// the pipeline has 9 stages of input and ln2 reduction, 20 Horner steps of 6 stages,
// OUT_WIDTH + 4 stages of quotient and rounding, and the output register.
// reset clears only the valid bits of the stages, the output register and the skid.
// a stalled result sits in the output register while the next one goes to the skid;
// o_stall is high only while the skid holds a result, and then the whole pipe holds.
module logistic_sigmoid_unit #(
    parameter int IN_WIDTH     = slu_pkg::DEF_IN_WIDTH,
    parameter int IN_FRAC_BITS = slu_pkg::DEF_IN_FRAC_BITS,
    parameter int OUT_WIDTH    = slu_pkg::DEF_OUT_WIDTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [IN_WIDTH-1:0]  i_x_value,
    input  logic                 i_last_in,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [OUT_WIDTH-1:0] o_y_value,
    output logic                 o_last_out
);

    localparam int N_STEP = slu_pkg::TAYLOR_ORDER;

    logic r_ov;
    logic r_sv;
    logic w_en;

    // the pipe moves whenever the skid is empty
    assign w_en    = ~r_sv;
    assign o_stall = r_sv;

    // range reduction
    logic            w_hv [0:N_STEP];
    slu_pkg::t_hdata w_hd [0:N_STEP];

    slu_range_reduce #(
        .IN_WIDTH     (IN_WIDTH),
        .IN_FRAC_BITS (IN_FRAC_BITS)
    ) u_range (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_x     (i_x_value),
        .i_last  (i_last_in),
        .o_valid (w_hv[0]),
        .o_data  (w_hd[0])
    );

    // Horner chain, highest divisor first
    for (genvar n = 0; n < N_STEP; n++) begin : g_horner
        slu_horner_step #(
            .DIVISOR (N_STEP - n)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_hv[n]),
            .i_data  (w_hd[n]),
            .o_valid (w_hv[n+1]),
            .o_data  (w_hd[n+1])
        );
    end

    // quotient and rounding
    logic                 w_pv;
    logic [OUT_WIDTH-1:0] w_py;
    logic                 w_plast;

    slu_recip #(
        .OUT_WIDTH (OUT_WIDTH)
    ) u_recip (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_valid   (w_hv[N_STEP]),
        .i_data    (w_hd[N_STEP]),
        .o_valid   (w_pv),
        .o_y_value (w_py),
        .o_last    (w_plast)
    );

    // output register and skid
    logic                 r_oy;
    logic [OUT_WIDTH-1:0] r_oy_val;
    logic                 r_ol;
    logic [OUT_WIDTH-1:0] r_sy_val;
    logic                 r_sl;
    logic                 n_ov;
    logic                 n_sv;
    logic                 w_ot;
    logic                 w_load_out;
    logic                 w_load_skid;
    logic                 w_move;

    assign w_ot = r_ov & ~i_stall;

    always_comb begin
        n_ov        = r_ov;
        n_sv        = r_sv;
        w_load_out  = 1'b0;
        w_load_skid = 1'b0;
        w_move      = 1'b0;
        if (!r_sv) begin
            if (w_pv) begin
                if (!r_ov || w_ot) begin
                    w_load_out = 1'b1;
                    n_ov       = 1'b1;
                end else begin
                    w_load_skid = 1'b1;
                    n_sv        = 1'b1;
                end
            end else if (w_ot) begin
                n_ov = 1'b0;
            end
        end else if (w_ot) begin
            w_move = 1'b1;
            n_sv   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else begin
            r_ov <= n_ov;
            r_sv <= n_sv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_oy_val <= w_py;
            r_ol     <= w_plast;
        end else if (w_move) begin
            r_oy_val <= r_sy_val;
            r_ol     <= r_sl;
        end
        if (w_load_skid) begin
            r_sy_val <= w_py;
            r_sl     <= w_plast;
        end
    end

    assign r_oy       = r_ov;
    assign o_valid    = r_oy;
    assign o_y_value  = r_oy_val;
    assign o_last_out = r_ol;

endmodule

// ===== sv/slu_range_reduce.sv =====
// input register, magnitude and ln2 range reduction of one element per cycle while i_en is high
module slu_range_reduce #(
    parameter int IN_WIDTH     = slu_pkg::DEF_IN_WIDTH,
    parameter int IN_FRAC_BITS = slu_pkg::DEF_IN_FRAC_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [IN_WIDTH-1:0]   i_x,
    input  logic                  i_last,
    output logic                  o_valid,
    output slu_pkg::t_hdata       o_data
);

    localparam int K_W   = slu_pkg::K_W;
    localparam int AV_W  = slu_pkg::AV_W;
    localparam int AV_SH = 56 - IN_FRAC_BITS;
    localparam logic [63:0] BIG = 64'(64) << IN_FRAC_BITS;

    // input stage
    logic                r_a_v;
    logic [IN_WIDTH-1:0] r_a_x;
    logic                r_a_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (i_en) begin
            r_a_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_x    <= i_x;
            r_a_last <= i_last;
        end
    end

    // magnitude, large range flag and Q8.56 argument
    logic                n_b_neg;
    logic [IN_WIDTH-1:0] n_b_mag;
    logic [63:0]         n_b_mag64;
    logic [63:0]         n_b_av64;
    logic                n_b_big;

    always_comb begin
        n_b_neg   = r_a_x[IN_WIDTH-1];
        n_b_mag   = n_b_neg ? (~r_a_x + IN_WIDTH'(1)) : r_a_x;
        n_b_mag64 = 64'(n_b_mag);
        n_b_big   = (n_b_mag64 >= BIG);
        n_b_av64  = n_b_mag64 << AV_SH;
    end

    // restoring division by ln2, one quotient bit per stage
    logic                r_v    [0:K_W];
    logic [AV_W-1:0]     r_rem  [0:K_W];
    logic [K_W-1:0]      r_kq   [0:K_W];
    logic                r_neg  [0:K_W];
    logic                r_big  [0:K_W];
    logic                r_last [0:K_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= r_a_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= n_b_av64[AV_W-1:0];
            r_kq[0]   <= '0;
            r_neg[0]  <= n_b_neg;
            r_big[0]  <= n_b_big;
            r_last[0] <= r_a_last;
        end
    end

    for (genvar i = 0; i < K_W; i++) begin : g_kstep
        localparam int SH = K_W - 1 - i;
        localparam logic [AV_W-1:0] DIV_C = AV_W'(slu_pkg::LN2_Q56) << SH;

        logic            n_ge;
        logic [AV_W-1:0] n_rem;
        logic [K_W-1:0]  n_k;

        always_comb begin
            n_ge      = (r_rem[i] >= DIV_C);
            n_rem     = n_ge ? (r_rem[i] - DIV_C) : r_rem[i];
            n_k       = r_kq[i];
            n_k[SH]   = n_ge;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i+1] <= 1'b0;
            end else if (i_en) begin
                r_v[i+1] <= r_v[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[i+1]  <= n_rem;
                r_kq[i+1]   <= n_k;
                r_neg[i+1]  <= r_neg[i];
                r_big[i+1]  <= r_big[i];
                r_last[i+1] <= r_last[i];
            end
        end
    end

    // remainder is below ln2, move it to Q62
    assign o_valid = r_v[K_W];

    always_comb begin
        o_data      = '0;
        o_data.r    = {r_rem[K_W][55:0], 6'b0};
        o_data.s    = slu_pkg::Q62_ONE;
        o_data.k    = r_kq[K_W];
        o_data.neg  = r_neg[K_W];
        o_data.big  = r_big[K_W];
        o_data.last = r_last[K_W];
    end

endmodule

// ===== sv/slu_horner_step.sv =====
// one Horner step s = 1 - floor(floor(r*s) / n) over six pipeline stages
module slu_horner_step #(
    parameter int DIVISOR = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  slu_pkg::t_hdata  i_data,
    output logic             o_valid,
    output slu_pkg::t_hdata  o_data
);

    localparam int R_W     = slu_pkg::R_W;
    localparam int S_W     = slu_pkg::S_W;
    localparam int REM_W   = slu_pkg::REM_W;
    localparam int CHUNK_W = slu_pkg::CHUNK_W;
    localparam int N_CHUNK = slu_pkg::N_CHUNK;
    localparam int P_W     = N_CHUNK * CHUNK_W;
    localparam int V_W     = REM_W + CHUNK_W;
    localparam int SHR     = V_W + REM_W;
    localparam int M_W     = SHR + 1;
    localparam int PR_W    = V_W + M_W;
    localparam logic [M_W-1:0] MULT = M_W'(((1 << SHR) + DIVISOR - 1) / DIVISOR);

    // partial products of r * s, 32 bit halves
    logic [63:0] n_m1_ll;
    logic [62:0] n_m1_lh;
    logic [61:0] n_m1_hl;
    logic [60:0] n_m1_hh;

    always_comb begin
        n_m1_ll = 64'(i_data.r[31:0]) * 64'(i_data.s[31:0]);
        n_m1_lh = 63'(i_data.r[31:0]) * 63'(i_data.s[S_W-1:32]);
        n_m1_hl = 62'(i_data.r[R_W-1:32]) * 62'(i_data.s[31:0]);
        n_m1_hh = 61'(i_data.r[R_W-1:32]) * 61'(i_data.s[S_W-1:32]);
    end

    logic            r_m1_v;
    logic [63:0]     r_m1_ll;
    logic [62:0]     r_m1_lh;
    logic [61:0]     r_m1_hl;
    logic [60:0]     r_m1_hh;
    slu_pkg::t_hdata r_m1_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_v <= 1'b0;
        end else if (i_en) begin
            r_m1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m1_ll <= n_m1_ll;
            r_m1_lh <= n_m1_lh;
            r_m1_hl <= n_m1_hl;
            r_m1_hh <= n_m1_hh;
            r_m1_d  <= i_data;
        end
    end

    // full product, keep bits from 2^62 up
    logic [63:0]  n_m2_mid;
    logic [127:0] n_m2_full;
    logic [R_W-1:0] n_m2_p;

    always_comb begin
        n_m2_mid  = 64'(r_m1_lh) + 64'(r_m1_hl);
        n_m2_full = {3'b0, r_m1_hh, r_m1_ll} + {32'b0, n_m2_mid, 32'b0};
        n_m2_p    = n_m2_full[123:62];
    end

    // constant divider stages, one 16 bit digit each
    logic               r_dv   [0:N_CHUNK];
    slu_pkg::t_hdata    r_dd   [0:N_CHUNK];
    logic [P_W-1:0]     r_dp   [0:N_CHUNK];
    logic [REM_W-1:0]   r_drem [0:N_CHUNK];
    logic [P_W-1:0]     r_dq   [0:N_CHUNK];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0] <= 1'b0;
        end else if (i_en) begin
            r_dv[0] <= r_m1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dd[0]   <= r_m1_d;
            r_dp[0]   <= P_W'(n_m2_p);
            r_drem[0] <= '0;
            r_dq[0]   <= '0;
        end
    end

    for (genvar j = 0; j < N_CHUNK; j++) begin : g_digit
        localparam bit LAST = (j == N_CHUNK - 1);

        logic [CHUNK_W-1:0] n_chunk;
        logic [V_W-1:0]     n_v;
        logic [PR_W-1:0]    n_prod;
        logic [CHUNK_W-1:0] n_digit;
        logic [V_W-1:0]     n_dn;
        logic [REM_W-1:0]   n_rem;
        logic [P_W-1:0]     n_q;
        slu_pkg::t_hdata    n_d;

        always_comb begin
            n_chunk = r_dp[j][P_W-1-j*CHUNK_W -: CHUNK_W];
            n_v     = {r_drem[j], n_chunk};
            n_prod  = PR_W'(n_v) * PR_W'(MULT);
            n_digit = n_prod[SHR +: CHUNK_W];
            n_dn    = V_W'(n_digit) * V_W'(DIVISOR);
            n_rem   = REM_W'(n_v - n_dn);
            n_q     = {r_dq[j][P_W-CHUNK_W-1:0], n_digit};
            n_d     = r_dd[j];
            // last digit closes the step with the new series value
            if (LAST) begin
                n_d.s = slu_pkg::Q62_ONE - n_q[S_W-1:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[j+1] <= 1'b0;
            end else if (i_en) begin
                r_dv[j+1] <= r_dv[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dd[j+1]   <= n_d;
                r_dp[j+1]   <= r_dp[j];
                r_drem[j+1] <= n_rem;
                r_dq[j+1]   <= n_q;
            end
        end
    end

    assign o_valid = r_dv[N_CHUNK];
    assign o_data  = r_dd[N_CHUNK];

endmodule

// ===== sv/slu_recip.sv =====
// scale of e^-|x|, quotient N/(1+E) one bit per stage, rounding and saturation
module slu_recip #(
    parameter int OUT_WIDTH = slu_pkg::DEF_OUT_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  slu_pkg::t_hdata       i_data,
    output logic                  o_valid,
    output logic [OUT_WIDTH-1:0]  o_y_value,
    output logic                  o_last
);

    localparam int S_W = slu_pkg::S_W;
    localparam int K_W = slu_pkg::K_W;
    localparam int D_W = slu_pkg::D_W;
    localparam int QW  = OUT_WIDTH + 2;

    // e^-|x| by shifting the series value, then numerator and divisor
    logic           n_e_zero;
    logic [S_W-1:0] n_e;
    logic [D_W-1:0] n_den;
    logic [D_W-1:0] n_num;

    always_comb begin
        n_e_zero = i_data.big | i_data.k[K_W-1];
        n_e      = n_e_zero ? '0 : (i_data.s >> i_data.k[K_W-2:0]);
        n_den    = D_W'(slu_pkg::Q62_ONE) + D_W'(n_e);
        n_num    = i_data.neg ? D_W'(n_e) : D_W'(slu_pkg::Q62_ONE);
    end

    logic           r_v    [0:QW];
    logic [D_W-1:0] r_den  [0:QW];
    logic [D_W-1:0] r_rem  [0:QW];
    logic [QW-1:0]  r_q    [0:QW];
    logic           r_last [0:QW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_den[0]  <= n_den;
            r_rem[0]  <= n_num;
            r_q[0]    <= '0;
            r_last[0] <= i_data.last;
        end
    end

    // restoring long division, first step without shift
    for (genvar j = 0; j < QW; j++) begin : g_qstep
        localparam bit SHIFT = (j != 0);

        logic [D_W-1:0] n_rs;
        logic           n_ge;
        logic [D_W-1:0] n_rem;
        logic [QW-1:0]  n_q;

        always_comb begin
            n_rs  = SHIFT ? {r_rem[j][D_W-2:0], 1'b0} : r_rem[j];
            n_ge  = (n_rs >= r_den[j]);
            n_rem = n_ge ? (n_rs - r_den[j]) : n_rs;
            n_q   = {r_q[j][QW-2:0], n_ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j+1] <= 1'b0;
            end else if (i_en) begin
                r_v[j+1] <= r_v[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[j+1]  <= r_den[j];
                r_rem[j+1]  <= n_rem;
                r_q[j+1]    <= n_q;
                r_last[j+1] <= r_last[j];
            end
        end
    end

    // round half up, clamp a code of one to all ones
    logic [QW:0]          n_qq;
    logic [QW-1:0]        n_yy;
    logic [OUT_WIDTH-1:0] n_y;

    always_comb begin
        n_qq = {1'b0, r_q[QW]} + (QW+1)'(1);
        n_yy = n_qq[QW:1];
        n_y  = (n_yy[QW-1:OUT_WIDTH] != '0) ? '1 : n_yy[OUT_WIDTH-1:0];
    end

    logic                 r_y_v;
    logic [OUT_WIDTH-1:0] r_y;
    logic                 r_y_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_y_v <= 1'b0;
        end else if (i_en) begin
            r_y_v <= r_v[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_y      <= n_y;
            r_y_last <= r_last[QW];
        end
    end

    assign o_valid   = r_y_v;
    assign o_y_value = r_y;
    assign o_last    = r_y_last;

endmodule

// ===== tb/sv/tb.sv =====
// testbench for the logistic sigmoid unit: driver tasks, result scoreboard and run control

// expected results of the sigmoid unit, in transfer order
class sigmoid_scoreboard;
    localparam int XW    = slu_pkg::DEF_IN_WIDTH;
    localparam int FRAC  = slu_pkg::DEF_IN_FRAC_BITS;
    localparam int YW    = slu_pkg::DEF_OUT_WIDTH;
    localparam int TERMS = 20;
    localparam logic [63:0] ONE_Q62 = 64'h4000_0000_0000_0000;
    localparam logic [63:0] LN2_FIX = 64'h00B1_7217_F7D1_CF7A;

    typedef struct packed {
        logic [XW-1:0] x;
        logic [YW-1:0] y;
        logic          last;
    } sigmoid_expect_t;

    sigmoid_expect_t expected_q[$];
    int unsigned     mismatches = 0;

    // e^-a in Q62 for a = mag / 2^FRAC, by ln2 reduction and a Horner series
    function logic [63:0] exp_neg_fix(logic [XW-1:0] mag);
        logic [63:0]  av;
        logic [63:0]  k;
        logic [63:0]  r;
        logic [63:0]  s;
        logic [127:0] prod;
        if (64'(mag) >= (64'd64 << FRAC))
            return 64'd0;
        av = 64'(mag) << (56 - FRAC);
        k  = av / LN2_FIX;
        r  = (av - k * LN2_FIX) << 6;
        s  = ONE_Q62;
        for (int n = TERMS; n >= 1; n--) begin
            prod = 128'(r) * 128'(s);
            s    = ONE_Q62 - 64'(prod >> 62) / 64'(n);
        end
        if (k > 64'd63)
            return 64'd0;
        return s >> k;
    endfunction

    // sigmoid of x as unsigned Q0.YW, rounded half up and saturated
    function logic [YW-1:0] sigmoid_code(logic [XW-1:0] x);
        logic         neg;
        logic [XW-1:0] mag;
        logic [63:0]  e;
        logic [63:0]  den;
        logic [63:0]  num;
        logic [127:0] q;
        logic [127:0] y;
        neg = x[XW-1];
        mag = neg ? -x : x;
        e   = exp_neg_fix(mag);
        den = ONE_Q62 + e;
        num = neg ? e : ONE_Q62;
        q   = (128'(num) << (YW + 1)) / 128'(den);
        y   = (q + 128'd1) >> 1;
        if (y[127:YW] != '0)
            return '1;
        return y[YW-1:0];
    endfunction

    // an accepted input transfer queues its result
    function void note_element(logic [XW-1:0] x, logic last);
        sigmoid_expect_t e;
        e.x    = x;
        e.y    = sigmoid_code(x);
        e.last = last;
        expected_q.push_back(e);
    endfunction

    // an accepted output transfer is matched against the oldest expectation
    function void check_output(logic [YW-1:0] y, logic last);
        sigmoid_expect_t e;
        if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("sigmoid check: output y=%0d last=%0b with nothing expected", y, last);
            return;
        end
        e = expected_q.pop_front();
        if (y !== e.y || last !== e.last) begin
            mismatches++;
            if (mismatches <= 10)
                $display("sigmoid check: x=%h expected y=%0d last=%0b, got y=%0d last=%0b",
                         e.x, e.y, e.last, y, last);
        end
    endfunction

    function int unsigned outstanding();
        return expected_q.size();
    endfunction
endclass

module tb;
    localparam int XW = slu_pkg::DEF_IN_WIDTH;
    localparam int YW = slu_pkg::DEF_OUT_WIDTH;
    localparam int LATENCY = YW + 133;
    localparam int RANDOM_ITEMS = 532;
    localparam int CALM_ITEMS = 60;
    localparam int unsigned CYCLE_LIMIT = 400000;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_valid;
    logic          o_stall;
    logic [XW-1:0] i_x_value;
    logic          i_last_in;
    logic          o_valid;
    logic          i_stall;
    logic [YW-1:0] o_y_value;
    logic          o_last_out;

    sigmoid_scoreboard sb;
    bit                calm = 1'b0;
    int unsigned       send_odds = 0;
    int unsigned       cycle_count = 0;

    logistic_sigmoid_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_x_value  (i_x_value),
        .i_last_in  (i_last_in),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_y_value  (o_y_value),
        .o_last_out (o_last_out)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("logistic_sigmoid_unit: mismatch");
            $finish;
        end
    end

    // monitor both channels at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (i_valid === 1'b1 && o_stall === 1'b0)
                sb.note_element(i_x_value, i_last_in);
            if (o_valid === 1'b1 && i_stall === 1'b0)
                sb.check_output(o_y_value, o_last_out);
        end
    end

    // receiver stall bursts, density changes from time to time
    initial begin
        int unsigned odds;
        int unsigned span;
        i_stall = 1'b0;
        odds = 0;
        forever begin
            @(negedge i_clk);
            if ($urandom_range(0, 63) == 0)
                odds = $urandom_range(0, 3);
            if (!calm && odds != 0 && $urandom_range(0, 4 * odds) == 0) begin
                span = $urandom_range(1, 18);
                i_stall = 1'b1;
                repeat (span) @(negedge i_clk);
                i_stall = 1'b0;
            end
        end
    end

    // one input transfer, with an optional idle burst ahead of it
    task automatic push_element(input logic [XW-1:0] xv, input logic lst);
        int unsigned gap;
        if (!calm && send_odds != 0 && $urandom_range(0, 3 * send_odds) == 0) begin
            gap = $urandom_range(1, 18);
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid   = 1'b1;
        i_x_value = xv;
        i_last_in = lst;
        @(posedge i_clk);
        while (o_stall !== 1'b0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // sender holds off until every queued result has come back
    task automatic drain_results();
        i_valid = 1'b0;
        while (sb.outstanding() != 0) @(negedge i_clk);
    endtask

    // stimulus and run control
    initial begin
        logic [XW-1:0] xv;
        logic          lst;
        sb        = new;
        i_rst_n   = 1'b0;
        i_valid   = 1'b0;
        i_x_value = '0;
        i_last_in = 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        // corners: zero, unit steps, extremes, around +-1 and +-ln2, wide patterns
        send_odds = 1;
        push_element(16'h0000, 1'b0);
        push_element(16'h0001, 1'b1);
        push_element(16'hFFFF, 1'b0);
        push_element(16'h7FFF, 1'b1);
        push_element(16'h8000, 1'b0);
        push_element(16'h8001, 1'b1);
        push_element(16'h7FFE, 1'b0);
        push_element(16'h1000, 1'b0);
        push_element(16'hF000, 1'b1);
        push_element(16'h0B17, 1'b0);
        push_element(16'hF4E9, 1'b0);
        push_element(16'h0B18, 1'b1);
        push_element(16'h4000, 1'b0);
        push_element(16'hC000, 1'b0);
        push_element(16'h0800, 1'b1);
        push_element(16'hF800, 1'b0);
        push_element(16'h5555, 1'b1);
        push_element(16'hAAAA, 1'b0);
        drain_results();

        // random elements, half of them wide, the rest within +-1 or near zero
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 40 == 0)
                send_odds = $urandom_range(0, 2);
            if (i == RANDOM_ITEMS / 2)
                drain_results();
            if (i == RANDOM_ITEMS - CALM_ITEMS)
                calm = 1'b1;
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: xv = XW'($urandom);
                5, 6, 7:       xv = XW'($urandom_range(0, 8191)) - XW'(4096);
                default:       xv = XW'($urandom_range(0, 63)) - XW'(32);
            endcase
            lst = ($urandom_range(0, 7) == 0);
            push_element(xv, lst);
        end
        i_valid = 1'b0;

        // wait out the pipe
        while (sb.outstanding() != 0) @(negedge i_clk);
        repeat (LATENCY + 20) @(negedge i_clk);
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("logistic_sigmoid_unit: match");
        else
            $display("logistic_sigmoid_unit: mismatch");
        $finish;
    end
endmodule
